// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, widths and codes for the strict priority four queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;
	localparam int NUM_CLASSES = 4;

	localparam int ID_FIELD_W  = 8;
	localparam int CLASS_W     = 2;
	localparam int COUNT_W     = 5;
	localparam int TOTAL_W     = 7;

	localparam int STORE_W     = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = CNT_W + 2;
	localparam int MEM_DEPTH   = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	localparam logic KIND_ENQUEUE  = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic [ID_FIELD_W-1:0] thread_id;
		logic [CLASS_W-1:0]    process_class;
	} req_t;

	typedef struct packed {
		logic                  granted;
		logic [ID_FIELD_W-1:0] dispatched_id;
		logic [CLASS_W-1:0]    queue_from;
		logic                  dropped;
		logic [COUNT_W-1:0]    system_count;
		logic [COUNT_W-1:0]    interactive_count;
		logic [COUNT_W-1:0]    normal_count;
		logic [COUNT_W-1:0]    batch_count;
		logic [TOTAL_W-1:0]    total_waiting;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic rsp_blocked;
	} sts_t;

endpackage

// ----- rtl/core/spq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/spq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accept a transaction, execute it, load the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = spq_pkg::S_EXEC;
				end
			end
			spq_pkg::S_EXEC: begin
				state_d = spq_pkg::S_LOAD;
			end
			spq_pkg::S_LOAD: begin
				if (!sts.rsp_blocked) begin
					state_d = spq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			spq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			spq_pkg::S_LOAD: begin
				cmd.load = !sts.rsp_blocked;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_exec_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::S_EXEC |=> state_q == spq_pkg::S_LOAD)
		else $error("exec not followed by load");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.exec, cmd.load}))
		else $error("overlapping commands");

	a_no_load_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.rsp_blocked)
		else $error("load while result register blocked");

endmodule

// ----- rtl/core/spq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: queue pointers and counts, shared entry store, result register.
// ----------------------------------------------------------------------------
module spq_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  spq_pkg::req_t req,
	input  spq_pkg::cmd_t cmd,
	output spq_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::req_t                    item_q;
	logic [spq_pkg::PTR_W-1:0]        head_q  [spq_pkg::NUM_CLASSES];
	logic [spq_pkg::PTR_W-1:0]        tail_q  [spq_pkg::NUM_CLASSES];
	logic [spq_pkg::CNT_W-1:0]        count_q [spq_pkg::NUM_CLASSES];
	logic [spq_pkg::CLASS_W-1:0]      last_q;
	logic                             grant_q;
	logic                             drop_q;
	logic                             rsp_valid_q;
	spq_pkg::rsp_t                    rsp_q;

	logic [spq_pkg::CLASS_W-1:0]      cls;
	logic                             full;
	logic                             any_ne;
	logic [spq_pkg::CLASS_W-1:0]      sel;
	logic                             do_enq;
	logic                             do_deq;
	logic [spq_pkg::ADDR_W-1:0]       waddr;
	logic [spq_pkg::ADDR_W-1:0]       raddr;
	logic [spq_pkg::STORE_W-1:0]      rdata;
	logic [spq_pkg::SUM_W-1:0]        total;

	function automatic logic [spq_pkg::PTR_W-1:0] advance(
		input logic [spq_pkg::PTR_W-1:0] p
	);
		return (p == spq_pkg::PTR_W'(spq_pkg::QUEUE_DEPTH - 1)) ?
			'0 : p + 1'b1;
	endfunction

	assign cls  = item_q.process_class;
	assign full = (count_q[cls] == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));

	always_comb begin
		any_ne = 1'b0;
		sel    = '0;
		for (int q = spq_pkg::NUM_CLASSES - 1; q >= 0; q--) begin
			if (count_q[q] != '0) begin
				any_ne = 1'b1;
				sel    = spq_pkg::CLASS_W'(q);
			end
		end
	end

	assign do_enq = cmd.exec && (item_q.kind == spq_pkg::KIND_ENQUEUE) && !full;
	assign do_deq = cmd.exec && (item_q.kind == spq_pkg::KIND_DISPATCH) && any_ne;

	assign waddr = spq_pkg::ADDR_W'(cls) * spq_pkg::ADDR_W'(spq_pkg::QUEUE_DEPTH)
		+ spq_pkg::ADDR_W'(tail_q[cls]);
	assign raddr = spq_pkg::ADDR_W'(sel) * spq_pkg::ADDR_W'(spq_pkg::QUEUE_DEPTH)
		+ spq_pkg::ADDR_W'(head_q[sel]);

	spq_ram #(
		.WIDTH (spq_pkg::STORE_W),
		.DEPTH (spq_pkg::MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_enq),
		.waddr (waddr),
		.wdata (item_q.thread_id[spq_pkg::STORE_W-1:0]),
		.re    (do_deq),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < spq_pkg::NUM_CLASSES; q++) begin
				head_q[q]  <= '0;
				tail_q[q]  <= '0;
				count_q[q] <= '0;
			end
			last_q  <= '0;
			grant_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (cmd.exec) begin
			grant_q <= do_deq;
			drop_q  <= (item_q.kind == spq_pkg::KIND_ENQUEUE) && full;
			if (do_enq) begin
				tail_q[cls]  <= advance(tail_q[cls]);
				count_q[cls] <= count_q[cls] + 1'b1;
			end
			if (do_deq) begin
				head_q[sel]  <= advance(head_q[sel]);
				count_q[sel] <= count_q[sel] - 1'b1;
				last_q       <= sel;
			end
		end
	end

	assign total = spq_pkg::SUM_W'(count_q[0]) + spq_pkg::SUM_W'(count_q[1])
		+ spq_pkg::SUM_W'(count_q[2]) + spq_pkg::SUM_W'(count_q[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.granted           <= grant_q;
			rsp_q.dispatched_id     <= grant_q ? spq_pkg::ID_FIELD_W'(rdata) : '0;
			rsp_q.queue_from        <= last_q;
			rsp_q.dropped           <= drop_q;
			rsp_q.system_count      <= spq_pkg::COUNT_W'(count_q[0]);
			rsp_q.interactive_count <= spq_pkg::COUNT_W'(count_q[1]);
			rsp_q.normal_count      <= spq_pkg::COUNT_W'(count_q[2]);
			rsp_q.batch_count       <= spq_pkg::COUNT_W'(count_q[3]);
			rsp_q.total_waiting     <= spq_pkg::TOTAL_W'(total);
		end
	end

	assign sts.rsp_blocked = rsp_valid_q && rsp_stall;
	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH) &&
		count_q[1] <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH) &&
		count_q[2] <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH) &&
		count_q[3] <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_enq |=> count_q[$past(cls)] == $past(count_q[cls]) + 1'b1)
		else $error("enqueue did not bump count");

	a_empty_keeps_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && item_q.kind == spq_pkg::KIND_DISPATCH && !any_ne |=> $stable(last_q))
		else $error("empty dispatch changed selected queue");

	a_grant_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.granted |-> !rsp_q.dropped)
		else $error("result both granted and dropped");

endmodule

// ----- rtl/core/strict_priority_four_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_four_queue_unit
// Four FIFO ready queues with strict priority dispatch, queue 0 highest.
// ----------------------------------------------------------------------------
// Each transaction is handled in order from acceptance to a loaded result:
// it is accepted, then the queue pointers are updated and the shared entry
// store is accessed, then the registered store read is captured into the
// result register; a new transaction is accepted only after the last one is
// loaded. The result register lets the next transaction be accepted while a
// result is still held by a stall; loading a new result waits until it is taken.
// Enqueues into a full queue are discarded and flagged as dropped.
module strict_priority_four_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- test/strict_priority_four_queue_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_four_queue_unit_tb
// Self-checking bench for the strict priority four queue unit. Directed
// transactions cover empty dispatch, every class, ID extremes and a full-queue
// drop. Random enqueue/dispatch mixes then fill and drain the queues under
// four sender/receiver idling phases. A scoreboard class keeps its own copy
// of the queues and checks every result field against it.
// ----------------------------------------------------------------------------
module strict_priority_four_queue_unit_tb;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT  = 10;
	localparam int PHASE_ITEMS = 313;
	localparam int SEG_ITEMS   = 52;

	localparam logic [CLASS_W-1:0] CLS_SYSTEM      = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_INTERACTIVE = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_NORMAL      = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_BATCH       = 2'd3;

	localparam logic [ID_FIELD_W-1:0] ID_MASK = (ID_WIDTH >= ID_FIELD_W) ?
		{ID_FIELD_W{1'b1}} : ID_FIELD_W'((1 << ID_WIDTH) - 1);

	class spq_scoreboard;
		logic [ID_FIELD_W-1:0] slots [NUM_CLASSES][QUEUE_DEPTH];
		int                    rd_idx [NUM_CLASSES];
		int                    wr_idx [NUM_CLASSES];
		int                    fill [NUM_CLASSES];
		logic [CLASS_W-1:0]    last_sel;
		rsp_t                  expected [$];
		int                    errors;
		int                    checked;
		int                    n_enq;
		int                    n_disp;
		int                    n_drop;
		int                    n_empty;
		int                    peak;

		function new();
			foreach (fill[q]) begin
				rd_idx[q] = 0;
				wr_idx[q] = 0;
				fill[q]   = 0;
			end
			last_sel = CLS_SYSTEM;
			errors   = 0;
			checked  = 0;
			n_enq    = 0;
			n_disp   = 0;
			n_drop   = 0;
			n_empty  = 0;
			peak     = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_request(req_t r);
			rsp_t                  e;
			logic [ID_FIELD_W-1:0] tid;
			int                    q;
			int                    sum;
			bit                    hit;
			e   = '0;
			tid = r.thread_id & ID_MASK;
			if (r.kind == KIND_ENQUEUE) begin
				n_enq++;
				if (fill[r.process_class] >= QUEUE_DEPTH) begin
					e.dropped = 1'b1;
					n_drop++;
				end else begin
					slots[r.process_class][wr_idx[r.process_class]] = tid;
					wr_idx[r.process_class] = (wr_idx[r.process_class] + 1) % QUEUE_DEPTH;
					fill[r.process_class]++;
					if (fill[r.process_class] > peak)
						peak = fill[r.process_class];
				end
			end else begin
				n_disp++;
				hit = 1'b0;
				for (q = 0; q < NUM_CLASSES && !hit; q++) begin
					if (fill[q] > 0) begin
						e.granted       = 1'b1;
						e.dispatched_id = slots[q][rd_idx[q]];
						rd_idx[q]       = (rd_idx[q] + 1) % QUEUE_DEPTH;
						fill[q]--;
						last_sel        = CLASS_W'(q);
						hit             = 1'b1;
					end
				end
				if (!hit)
					n_empty++;
			end
			sum = fill[0] + fill[1] + fill[2] + fill[3];
			e.queue_from        = last_sel;
			e.system_count      = COUNT_W'(fill[0]);
			e.interactive_count = COUNT_W'(fill[1]);
			e.normal_count      = COUNT_W'(fill[2]);
			e.batch_count       = COUNT_W'(fill[3]);
			e.total_waiting     = TOTAL_W'(sum);
			expected.push_back(e);
		endfunction

		function void check_response(rsp_t act);
			rsp_t e;
			bit   bad;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("[%0t] result with nothing expected: %h", $realtime, act);
				return;
			end
			e   = expected.pop_front();
			bad = (act.granted !== e.granted) ||
				(act.dispatched_id !== e.dispatched_id) ||
				(act.queue_from !== e.queue_from) ||
				(act.dropped !== e.dropped) ||
				(act.system_count !== e.system_count) ||
				(act.interactive_count !== e.interactive_count) ||
				(act.normal_count !== e.normal_count) ||
				(act.batch_count !== e.batch_count) ||
				(act.total_waiting !== e.total_waiting);
			checked++;
			if (bad) begin
				errors++;
				if (errors <= SHOW_LIMIT) begin
					$display("[%0t] mismatch on result %0d", $realtime, checked);
					$display("  exp gnt=%b id=%h from=%0d drop=%b cnt=%0d/%0d/%0d/%0d tot=%0d",
						e.granted, e.dispatched_id, e.queue_from, e.dropped,
						e.system_count, e.interactive_count, e.normal_count,
						e.batch_count, e.total_waiting);
					$display("  act gnt=%b id=%h from=%0d drop=%b cnt=%0d/%0d/%0d/%0d tot=%0d",
						act.granted, act.dispatched_id, act.queue_from, act.dropped,
						act.system_count, act.interactive_count, act.normal_count,
						act.batch_count, act.total_waiting);
				end
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	int    idle_pct;
	int    stall_pct;
	int    cycle_count;

	spq_scoreboard sb = new();

	strict_priority_four_queue_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
		$display("Verification failed");
		$finish;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	function automatic req_t make_req(logic kind, logic [ID_FIELD_W-1:0] id,
		logic [CLASS_W-1:0] cls);
		req_t r;
		r.kind          = kind;
		r.thread_id     = id;
		r.process_class = cls;
		return r;
	endfunction

	function automatic int idle_gap();
		int g;
		g = 0;
		while (g < 40 && $urandom_range(99) < idle_pct)
			g++;
		return g;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
			req       <= req_t'($urandom);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int items);
		req_t               r;
		int                 n;
		int                 enq_pct;
		logic [CLASS_W-1:0] fav;
		for (n = 0; n < items; n++) begin
			if (n % SEG_ITEMS == 0) begin
				case ($urandom_range(3))
					0: enq_pct = 30;
					1: enq_pct = 50;
					2: enq_pct = 70;
					default: enq_pct = 90;
				endcase
				fav = CLASS_W'($urandom);
			end
			r = make_req(($urandom_range(99) < enq_pct) ? KIND_ENQUEUE : KIND_DISPATCH,
				ID_FIELD_W'($urandom), $urandom_range(1) ? fav : CLASS_W'($urandom));
			send_request(r);
		end
	endtask

	initial begin
		int i;
		int ph;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;
		idle_pct  = 20;
		stall_pct = 20;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty dispatch, one per class, priority order, then a full queue
		send_request(make_req(KIND_DISPATCH, 8'hFF, CLS_BATCH));
		send_request(make_req(KIND_ENQUEUE, 8'hFF, CLS_BATCH));
		send_request(make_req(KIND_ENQUEUE, 8'h00, CLS_SYSTEM));
		send_request(make_req(KIND_ENQUEUE, 8'hA5, CLS_INTERACTIVE));
		send_request(make_req(KIND_ENQUEUE, 8'h5A, CLS_NORMAL));
		for (i = 0; i < 5; i++)
			send_request(make_req(KIND_DISPATCH, ID_FIELD_W'($urandom), CLASS_W'($urandom)));
		for (i = 0; i < QUEUE_DEPTH; i++)
			send_request(make_req(KIND_ENQUEUE, ID_FIELD_W'(i * 17), CLS_NORMAL));
		send_request(make_req(KIND_ENQUEUE, 8'h3C, CLS_NORMAL));
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			run_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d transactions: %0d enqueues with %0d dropped, %0d dispatches with %0d empty",
			sb.n_enq + sb.n_disp, sb.n_enq, sb.n_drop, sb.n_disp, sb.n_empty);
		$display("Peak queue occupancy %0d of %0d across four idling phases; %0d checked, %0d bad",
			sb.peak, QUEUE_DEPTH, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
